### rtl/checksum_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// Checksum frame deframer assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef CHECKSUM_FRAME_DEFRAMER_DEFINES_SVH
`define CHECKSUM_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define CFD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// Checksum frame deframer package
// Shared constants, register indexes and result status codes.
// ----------------------------------------------------------------------------
package cfd_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 8;
	localparam int BYTE_W          = 8;
	localparam int POS_W           = 5;

	localparam logic [BYTE_W-1:0] HEADER_RST = 8'h55;
	localparam logic [BYTE_W-1:0] ID_RST     = 8'h40;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ID     = 1'd1;

	typedef enum logic [1:0] {
		ST_PAYLOAD   = 2'd0,
		ST_CKSUM_ERR = 2'd1,
		ST_EMPTY_OK  = 2'd2,
		ST_TOO_LONG  = 2'd3
	} status_t;

endpackage

### rtl/cfd_ifs.sv
// ----------------------------------------------------------------------------
// Checksum frame deframer channels
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfd_in_if import cfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if import cfd_pkg::*; ();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [POS_W-1:0]  position;
	logic [BYTE_W-1:0] payload_value;
	logic              last;

	modport source (output valid, output status, output position, output payload_value,
		output last, input ready);
	modport sink   (input valid, input status, input position, input payload_value,
		input last, output ready);
endinterface

### rtl/checksum_frame_deframer.sv
// ----------------------------------------------------------------------------
// Checksum frame deframer
// Header / ID / length / payload / additive checksum frame parser.
// ----------------------------------------------------------------------------
// Channel  Dir  Item                                         Handshake
// rx       in   rx_byte                                      valid/ready
// tx       out  status, position, payload_value, last        valid/ready
//
// One received byte per cycle while parsing and the output register is free.
// A good frame with payload releases its bytes from the payload memory,
// each result by a memory read, then a load of the output register; no byte is
// taken until the last payload result is loaded.
// arst_n clears the parser and the output valid flag; the memory needs no clear.
// A stalled tx holds the output register and stops intake.
// ----------------------------------------------------------------------------
module checksum_frame_deframer import cfd_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cfd_in_if.sink                rx,
	cfd_out_if.source             tx
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LW = $clog2(MAX_PAYLOAD + 1);

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;

	cfd_ctrl #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.AW         (AW),
		.LW         (LW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rx       (rx),
		.tx       (tx),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	cfd_store #(
		.DEPTH(MAX_PAYLOAD),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

### rtl/cfd_store.sv
// ----------------------------------------------------------------------------
// Payload store
// Single-port-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module cfd_store import cfd_pkg::*; #(
	parameter int DEPTH = MAX_PAYLOAD_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// Deframer control
// Frame parser, checksum, store addressing, payload burst and output register.
// ----------------------------------------------------------------------------
module cfd_ctrl import cfd_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
	parameter int LW          = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cfd_in_if.sink               rx,
	cfd_out_if.source            tx,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [BYTE_W-1:0]    wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  logic [BYTE_W-1:0]    rd_data
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ID,
		PH_LEN,
		PH_DATA,
		PH_SUM,
		PH_EMIT_RD,
		PH_EMIT_OUT
	} phase_t;

	phase_t            phase_q;
	logic [BYTE_W-1:0] hdr_q;
	logic [BYTE_W-1:0] id_q;
	logic [BYTE_W-1:0] sum_q;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     seen_q;
	logic [LW-1:0]     idx_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [BYTE_W-1:0] out_value_q;
	logic              out_last_q;

	logic              out_free;
	logic              parsing;
	logic              acc;
	logic [BYTE_W-1:0] b;
	logic [LW-1:0]     seen_nxt;
	logic [LW-1:0]     idx_nxt;
	logic              idx_last;

	assign out_free = !out_valid_q || tx.ready;
	assign parsing  = (phase_q == PH_HUNT) || (phase_q == PH_ID) || (phase_q == PH_LEN) ||
		(phase_q == PH_DATA) || (phase_q == PH_SUM);
	assign rx.ready = parsing && out_free;
	assign acc      = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign seen_nxt = seen_q + LW'(1);
	assign idx_nxt  = idx_q + LW'(1);
	assign idx_last = (idx_nxt == len_q);

	assign wr_en   = acc && (phase_q == PH_DATA);
	assign wr_addr = seen_q[AW-1:0];
	assign wr_data = b;
	assign rd_en   = (phase_q == PH_EMIT_RD);
	assign rd_addr = idx_q[AW-1:0];

	assign tx.valid         = out_valid_q;
	assign tx.status        = out_status_q;
	assign tx.position      = out_pos_q;
	assign tx.payload_value = out_value_q;
	assign tx.last          = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			hdr_q       <= HEADER_RST;
			id_q        <= ID_RST;
			sum_q       <= '0;
			len_q       <= '0;
			seen_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HEADER: hdr_q <= cfg_data;
					CFG_ID:     id_q  <= cfg_data;
					default:    ;
				endcase
			end
			if (out_valid_q && tx.ready) begin
				out_valid_q <= 1'b0;
			end
			case (phase_q)
				PH_HUNT: begin
					if (acc && (b == hdr_q)) begin
						sum_q   <= b;
						phase_q <= PH_ID;
					end
				end
				PH_ID: begin
					if (acc) begin
						if (b == id_q) begin
							sum_q   <= sum_q + b;
							phase_q <= PH_LEN;
						end else begin
							phase_q <= PH_HUNT;
						end
					end
				end
				PH_LEN: begin
					if (acc) begin
						if (b > 8'(MAX_PAYLOAD)) begin
							out_valid_q  <= 1'b1;
							out_status_q <= ST_TOO_LONG;
							out_pos_q    <= '0;
							out_value_q  <= '0;
							out_last_q   <= 1'b1;
							phase_q      <= PH_HUNT;
						end else begin
							len_q   <= b[LW-1:0];
							seen_q  <= '0;
							sum_q   <= sum_q + b;
							phase_q <= (b == '0) ? PH_SUM : PH_DATA;
						end
					end
				end
				PH_DATA: begin
					if (acc) begin
						sum_q  <= sum_q + b;
						seen_q <= seen_nxt;
						if (seen_nxt >= len_q) begin
							phase_q <= PH_SUM;
						end
					end
				end
				PH_SUM: begin
					if (acc) begin
						if (b != sum_q) begin
							out_valid_q  <= 1'b1;
							out_status_q <= ST_CKSUM_ERR;
							out_pos_q    <= '0;
							out_value_q  <= '0;
							out_last_q   <= 1'b1;
							phase_q      <= PH_HUNT;
						end else if (len_q == '0) begin
							out_valid_q  <= 1'b1;
							out_status_q <= ST_EMPTY_OK;
							out_pos_q    <= '0;
							out_value_q  <= '0;
							out_last_q   <= 1'b1;
							phase_q      <= PH_HUNT;
						end else begin
							idx_q   <= '0;
							phase_q <= PH_EMIT_RD;
						end
					end
				end
				PH_EMIT_RD: begin
					phase_q <= PH_EMIT_OUT;
				end
				PH_EMIT_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_PAYLOAD;
						out_pos_q    <= POS_W'(idx_q);
						out_value_q  <= rd_data;
						out_last_q   <= idx_last;
						idx_q        <= idx_nxt;
						phase_q      <= idx_last ? PH_HUNT : PH_EMIT_RD;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

endmodule

### rtl/cfd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Port-level assertions on the deframer, attached by bind.
// ----------------------------------------------------------------------------
`include "checksum_frame_deframer_defines.svh"

module cfd_checker import cfd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [POS_W-1:0]  position,
	input logic [BYTE_W-1:0] payload_value,
	input logic              last
);

	`CFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "tx item dropped while stalled")
	`CFD_ASSERT_SAME(a_status_only, out_valid && (status != ST_PAYLOAD), (position == '0) && (payload_value == '0) && last, "status item with payload fields")
	`CFD_ASSERT_SAME(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "rx taken while tx stalled")
	`CFD_ASSERT_NEXT(a_burst_blocks_in, out_valid && out_ready && (status == ST_PAYLOAD) && !last, !in_ready || (out_valid && (status == ST_PAYLOAD) && last), "rx taken inside payload burst")

endmodule

bind checksum_frame_deframer cfd_checker u_cfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (rx.valid),
	.in_ready     (rx.ready),
	.out_valid    (tx.valid),
	.out_ready    (tx.ready),
	.status       (tx.status),
	.position     (tx.position),
	.payload_value(tx.payload_value),
	.last         (tx.last)
);
